### hw/rtl/cst_pkg.sv
// counting semaphore table: shared types, constants and codes
// used by cst_alloc and counting_semaphore_table_core; no dependencies
package cst_pkg;

  // table geometry
  localparam int unsigned NumSems    = 256;
  localparam int unsigned NumThreads = 16;
  localparam int unsigned CountW     = 16;

  localparam int unsigned SemW  = $clog2(NumSems);
  localparam int unsigned ThrW  = $clog2(NumThreads);
  localparam int unsigned HeadW = ThrW + 1;

  // slot allocator: in-use bits grouped in rows
  localparam int unsigned GrpSize = 16;
  localparam int unsigned NumGrps = NumSems / GrpSize;
  localparam int unsigned BitW    = $clog2(GrpSize);
  localparam int unsigned GrpW    = SemW - BitW;

  // empty-list mark of a wait list
  localparam logic [HeadW-1:0] NoThread = HeadW'(NumThreads);

  typedef enum logic [1:0] {
    OpCreate = 2'd0,
    OpDelete = 2'd1,
    OpTake   = 2'd2,
    OpGive   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNoSem   = 3'd1,
    StWaiters = 3'd2,
    StFull    = 3'd3,
    StBlocked = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SAlloc,
    SExec,
    SPop
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [7:0]  sem_index;
    logic [3:0]  caller_thread;
    logic [15:0] initial_coins;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot_out;
    logic       woken_valid;
    logic [3:0] woken_thread;
  } rsp_t;

  // one semaphore entry in the table memory
  typedef struct packed {
    logic [HeadW-1:0]  head;
    logic [CountW-1:0] coins;
  } ent_t;

  // update of the in-use bits
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [SemW-1:0] slot;
  } alloc_cmd_t;

endpackage

### hw/rtl/cst_alloc.sv
// slot allocator: in-use bit per semaphore and two-step lowest-free search
// depends on cst_pkg
module cst_alloc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  find_i,
  input  cst_pkg::alloc_cmd_t   cmd_i,
  input  logic [cst_pkg::SemW-1:0] query_slot_i,
  output logic                  in_use_o,
  output logic                  free_ok_o,
  output logic [cst_pkg::SemW-1:0] free_slot_o
);
  import cst_pkg::*;

  logic [GrpSize-1:0] in_use_q [NumGrps];
  logic [NumGrps-1:0] grp_free;
  logic [GrpW-1:0]    grp_d, grp_q;
  logic               any_d, any_q;
  logic [GrpSize-1:0] row;
  logic [BitW-1:0]    bit_sel;

  // in-use bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NumGrps; g++) begin
        in_use_q[g] <= '0;
      end
    end else if (cmd_i.set) begin
      in_use_q[cmd_i.slot[SemW-1:BitW]][cmd_i.slot[BitW-1:0]] <= 1'b1;
    end else if (cmd_i.clr) begin
      in_use_q[cmd_i.slot[SemW-1:BitW]][cmd_i.slot[BitW-1:0]] <= 1'b0;
    end
  end

  assign in_use_o = in_use_q[query_slot_i[SemW-1:BitW]][query_slot_i[BitW-1:0]];

  // first step: lowest row with a free slot
  always_comb begin
    grp_d = '0;
    for (int g = 0; g < NumGrps; g++) begin
      grp_free[g] = ~&in_use_q[g];
    end
    for (int g = NumGrps - 1; g >= 0; g--) begin
      if (grp_free[g]) grp_d = GrpW'(g);
    end
    any_d = |grp_free;
  end

  always_ff @(posedge clk_i) begin
    if (find_i) begin
      grp_q <= grp_d;
      any_q <= any_d;
    end
  end

  // second step: lowest free bit inside the chosen row
  always_comb begin
    row     = in_use_q[grp_q];
    bit_sel = '0;
    for (int b = GrpSize - 1; b >= 0; b--) begin
      if (!row[b]) bit_sel = BitW'(b);
    end
  end

  assign free_ok_o   = any_q;
  assign free_slot_o = {grp_q, bit_sel};

endmodule

### hw/rtl/counting_semaphore_table_core.sv
// counting semaphore table top level: request decode, table memories, sequencer
// depends on cst_pkg and cst_alloc
//
// Usage:
//   A request (req_i: opcode, sem_index, caller_thread, initial_coins) is taken
//   at a rising edge with start high and busy low. busy stays high while the
//   request is worked on; one request is in the block at a time.
//   Exactly one result (res_o) appears, marked by done_o for one cycle. The
//   receiver cannot stall: the result is taken at the edge ending that cycle.
// Sequence:
//   create passes SAlloc, delete, take and give without a waiter pass SExec
//   before done; a give that wakes a thread passes SExec, then SPop, as the
//   popped thread's next pointer is read from the waiter memory after the
//   entry read. The semaphore memory is read synchronously at accept; create,
//   take and give write it at most once, delete only clears the in-use bit.
//   A new request may be taken in the cycle done_o is high.
// Reset:
//   All slots become free at once (in-use flip-flops); entry and waiter
//   memories need no clearing, as create writes an entry before any use.
module counting_semaphore_table_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  cst_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output cst_pkg::rsp_t res_o
);
  import cst_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic   accept;

  // semaphore entry memory and per-thread next pointer memory
  ent_t             sem_mem [NumSems];
  logic [HeadW-1:0] nw_mem  [NumThreads];
  ent_t             ent_rd_q;
  logic [HeadW-1:0] nw_rd_q;

  logic             sem_we;
  logic [SemW-1:0]  sem_wa;
  ent_t             sem_wd;
  logic             nw_we;
  logic [ThrW-1:0]  nw_wa;
  logic [HeadW-1:0] nw_wd;
  logic             nw_re;
  logic [ThrW-1:0]  nw_ra;

  alloc_cmd_t      acmd;
  logic            in_use;
  logic            free_ok;
  logic [SemW-1:0] free_slot;

  rsp_t res_d, res_q;
  logic done_d, done_q;

  logic slot_ok;
  logic caller_ok;
  logic head_ok;

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);

  cst_alloc u_alloc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .find_i       (accept),
    .cmd_i        (acmd),
    .query_slot_i (req_q.sem_index),
    .in_use_o     (in_use),
    .free_ok_o    (free_ok),
    .free_slot_o  (free_slot)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // memories: entry read at accept, writes from the sequencer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_rd_q <= sem_mem[req_i.sem_index];
    end
    if (sem_we) begin
      sem_mem[sem_wa] <= sem_wd;
    end
    if (nw_re) begin
      nw_rd_q <= nw_mem[nw_ra];
    end
    if (nw_we) begin
      nw_mem[nw_wa] <= nw_wd;
    end
  end

  assign slot_ok   = (32'(req_q.sem_index) < NumSems) && in_use;
  assign caller_ok = (32'(req_q.caller_thread) < NumThreads);
  assign head_ok   = (32'(ent_rd_q.head) < NumThreads);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // sequencer: next state, memory writes and result
  always_comb begin
    state_d  = state_q;
    sem_we   = 1'b0;
    sem_wa   = req_q.sem_index;
    sem_wd   = ent_rd_q;
    nw_we    = 1'b0;
    nw_wa    = req_q.caller_thread;
    nw_wd    = ent_rd_q.head;
    nw_re    = 1'b0;
    nw_ra    = ent_rd_q.head[ThrW-1:0];
    acmd     = '{set: 1'b0, clr: 1'b0, slot: req_q.sem_index};
    res_d    = '0;
    done_d   = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = (req_i.opcode == OpCreate) ? SAlloc : SExec;
        end
      end

      // create: claim the lowest free slot
      SAlloc: begin
        state_d = SIdle;
        done_d  = 1'b1;
        if (free_ok) begin
          sem_we       = 1'b1;
          sem_wa       = free_slot;
          sem_wd.head  = NoThread;
          sem_wd.coins = CountW'(req_q.initial_coins);
          acmd.set     = 1'b1;
          acmd.slot    = free_slot;
          res_d.status   = StOk;
          res_d.slot_out = free_slot;
        end else begin
          res_d.status = StFull;
        end
      end

      // delete, take, give on the fetched entry
      SExec: begin
        state_d        = SIdle;
        done_d         = 1'b1;
        res_d.slot_out = req_q.sem_index;
        if (!slot_ok) begin
          res_d.status = StNoSem;
        end else begin
          unique case (req_q.opcode)
            OpDelete: begin
              if (ent_rd_q.head != NoThread) begin
                res_d.status = StWaiters;
              end else begin
                acmd.clr     = 1'b1;
                res_d.status = StOk;
              end
            end
            OpTake: begin
              if (ent_rd_q.coins != '0) begin
                sem_we       = 1'b1;
                sem_wd.coins = ent_rd_q.coins - 1'b1;
                res_d.status = StOk;
              end else begin
                // push the caller onto the wait list
                if (caller_ok) begin
                  nw_we       = 1'b1;
                  sem_we      = 1'b1;
                  sem_wd.head = HeadW'(req_q.caller_thread);
                end
                res_d.status = StBlocked;
              end
            end
            OpGive: begin
              if (head_ok) begin
                nw_re   = 1'b1;
                state_d = SPop;
                done_d  = 1'b0;
              end else begin
                if (ent_rd_q.coins != '1) begin
                  sem_we       = 1'b1;
                  sem_wd.coins = ent_rd_q.coins + 1'b1;
                end
                res_d.status = StOk;
              end
            end
            default: begin
              res_d.status = StOk;
            end
          endcase
        end
      end

      // give: pop the newest waiter
      SPop: begin
        state_d            = SIdle;
        done_d             = 1'b1;
        sem_we             = 1'b1;
        sem_wd.head        = nw_rd_q;
        res_d.status       = StOk;
        res_d.slot_out     = req_q.sem_index;
        res_d.woken_valid  = 1'b1;
        res_d.woken_thread = ent_rd_q.head[ThrW-1:0];
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("request accepted but block not busy");

  // a result only follows a cycle of work
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result strobe without a request in work");

  // a woken thread always comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.woken_valid |-> res_o.status == StOk)
    else $error("woken thread with error status");

  // no thread is reported when none was woken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.woken_valid |-> res_o.woken_thread == '0)
    else $error("stray woken thread");
`endif

endmodule
